// ===== sv/tlrc_pkg.sv =====
// shared constants and controller/datapath interface types for the thick line rasterizer
package tlrc_pkg;

    // field and datapath widths
    localparam int COORD_BITS    = 13;
    localparam int MAX_THICKNESS = 63;
    localparam int ADDR_BITS     = 24;
    localparam int CFG_BITS      = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int WIDTH_BITS    = 6;
    localparam int RAD_BITS      = WIDTH_BITS - 1;
    localparam int OFF_BITS      = RAD_BITS + 1;
    localparam int SQ_BITS       = 2 * RAD_BITS;
    localparam int PIX_BITS      = 12;
    localparam int COLOR_BITS    = 32;
    localparam int OUT_ADDR_BITS = 24;
    localparam int PROD_BITS     = COORD_BITS + CFG_BITS;

    // stream packing
    localparam int S_DATA_BITS = 96;
    localparam int M_DATA_BITS = 80;

    // opcodes carried in s_tuser
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PITCH    = 2'd2;

    // register reset values
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 13'd1920;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 13'd1080;
    localparam logic [CFG_BITS-1:0] ROW_PITCH_RST    = 13'd1920;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_line;
        logic eval;
        logic mul;
        logic load_out;
    } tlrc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic cand_last;
    } tlrc_status_t;

endpackage

// ===== sv/tlrc_datapath.sv =====
// line state, brush scan, incremental centre stepping, address multiply and output register
module tlrc_datapath import tlrc_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tlrc_cmd_t                     cmd,
    output tlrc_status_t                  status,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_data,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,
    input  logic [WIDTH_BITS-1:0]         stroke_width,
    input  logic [COLOR_BITS-1:0]         pen_color,
    output logic [OUT_ADDR_BITS-1:0]      address,
    output logic [PIX_BITS-1:0]           pixel_col,
    output logic [PIX_BITS-1:0]           pixel_row,
    output logic [COLOR_BITS-1:0]         write_color,
    output logic                          write_enable,
    output logic                          last
);

    localparam int CW = COORD_BITS;
    localparam int PW = COORD_BITS + 1;

    // configuration registers
    logic [CFG_BITS-1:0] frame_width_reg, frame_height_reg, row_pitch_reg;

    // line state
    logic signed [CW-1:0]       x0_reg, y0_reg;
    logic [CW-1:0]              adx_reg, ady_reg;
    logic                       negx_reg, negy_reg;
    logic [CW-1:0]              qx_reg, qy_reg, remx_reg, remy_reg;
    logic [CW-1:0]              step_total_reg, step_index_reg;
    logic signed [CW-1:0]       cen_x_reg, cen_y_reg;
    logic signed [OFF_BITS-1:0] off_col_reg, off_row_reg;
    logic [RAD_BITS-1:0]        radius_reg;
    logic [SQ_BITS-1:0]         rsq_reg;
    logic [COLOR_BITS-1:0]      held_color_reg;

    // candidate and multiply stage
    logic [CW-1:0]        cand_px_reg, cand_py_reg;
    logic                 cand_we_reg, cand_last_reg;
    logic [PROD_BITS-1:0] prod_reg;

    // output payload
    logic [OUT_ADDR_BITS-1:0] addr_reg;
    logic [PIX_BITS-1:0]      col_reg, row_reg;
    logic [COLOR_BITS-1:0]    color_reg;
    logic                     we_reg, last_reg;

    // line setup terms
    logic signed [PW-1:0]  dx_w, dy_w, adx_full, ady_full;
    logic [CW-1:0]         adx_w, ady_w, steps_max, steps_w;
    logic [WIDTH_BITS-1:0] thick_w;
    logic [RAD_BITS-1:0]   rad_w;
    logic [SQ_BITS-1:0]    rsq_w;

    // candidate terms
    logic signed [PW-1:0]       px_w, py_w;
    logic [RAD_BITS-1:0]        acol_w, arow_w;
    logic [SQ_BITS:0]           dist_w;
    logic                       in_disc, in_frame, col_end, row_end, is_last;
    logic signed [OFF_BITS-1:0] rad_s;

    // step advance terms
    logic [CW:0]          r2x_w, r2y_w;
    logic                 gex_w, gey_w;
    logic [CW-1:0]        qx_next, qy_next, remx_next, remy_next;
    logic signed [PW-1:0] cenx_next_w, ceny_next_w;

    // output add
    logic [PROD_BITS:0] addr_sum_w;

    // line setup: step count, radius, radius squared
    always_comb begin
        dx_w     = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
        dy_w     = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
        adx_full = dx_w[PW-1] ? -dx_w : dx_w;
        ady_full = dy_w[PW-1] ? -dy_w : dy_w;
        adx_w    = adx_full[CW-1:0];
        ady_w    = ady_full[CW-1:0];
        steps_max = (adx_w > ady_w) ? adx_w : ady_w;
        steps_w   = (steps_max == '0) ? CW'(1) : steps_max;
        thick_w   = (stroke_width > WIDTH_BITS'(MAX_THICKNESS)) ?
                    WIDTH_BITS'(MAX_THICKNESS) : stroke_width;
        rad_w     = thick_w[WIDTH_BITS-1:1];
        rsq_w     = SQ_BITS'(rad_w) * SQ_BITS'(rad_w);
    end

    // candidate pixel, disc and frame tests
    always_comb begin
        px_w    = {cen_x_reg[CW-1], cen_x_reg}
                + {{(PW-OFF_BITS){off_col_reg[OFF_BITS-1]}}, off_col_reg};
        py_w    = {cen_y_reg[CW-1], cen_y_reg}
                + {{(PW-OFF_BITS){off_row_reg[OFF_BITS-1]}}, off_row_reg};
        acol_w  = off_col_reg[OFF_BITS-1] ? RAD_BITS'(-off_col_reg) : RAD_BITS'(off_col_reg);
        arow_w  = off_row_reg[OFF_BITS-1] ? RAD_BITS'(-off_row_reg) : RAD_BITS'(off_row_reg);
        dist_w  = (SQ_BITS+1)'(SQ_BITS'(acol_w) * SQ_BITS'(acol_w))
                + (SQ_BITS+1)'(SQ_BITS'(arow_w) * SQ_BITS'(arow_w));
        in_disc = dist_w <= {1'b0, rsq_reg};
        in_frame = !px_w[PW-1] && !py_w[PW-1] &&
                   (px_w[CW-1:0] < frame_width_reg) && (py_w[CW-1:0] < frame_height_reg);
        rad_s   = {1'b0, radius_reg};
        col_end = off_col_reg == rad_s;
        row_end = off_row_reg == rad_s;
        is_last = (step_index_reg == step_total_reg) && row_end && col_end;
    end

    assign status.cand_last = is_last;

    // next centre: quotient and remainder of |delta|*i/steps kept incrementally
    always_comb begin
        r2x_w     = {1'b0, remx_reg} + {1'b0, adx_reg};
        r2y_w     = {1'b0, remy_reg} + {1'b0, ady_reg};
        gex_w     = r2x_w >= {1'b0, step_total_reg};
        gey_w     = r2y_w >= {1'b0, step_total_reg};
        remx_next = gex_w ? CW'(r2x_w - {1'b0, step_total_reg}) : r2x_w[CW-1:0];
        remy_next = gey_w ? CW'(r2y_w - {1'b0, step_total_reg}) : r2y_w[CW-1:0];
        qx_next   = gex_w ? qx_reg + CW'(1) : qx_reg;
        qy_next   = gey_w ? qy_reg + CW'(1) : qy_reg;
        cenx_next_w = negx_reg ? {x0_reg[CW-1], x0_reg} - {1'b0, qx_next}
                               : {x0_reg[CW-1], x0_reg} + {1'b0, qx_next};
        ceny_next_w = negy_reg ? {y0_reg[CW-1], y0_reg} - {1'b0, qy_next}
                               : {y0_reg[CW-1], y0_reg} + {1'b0, qy_next};
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            row_pitch_reg    <= ROW_PITCH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_ROW_PITCH:    row_pitch_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // line latch and scan advance
    always_ff @(posedge aclk) begin
        if (cmd.load_line) begin
            x0_reg         <= start_x;
            y0_reg         <= start_y;
            adx_reg        <= adx_w;
            ady_reg        <= ady_w;
            negx_reg       <= dx_w[PW-1];
            negy_reg       <= dy_w[PW-1];
            qx_reg         <= '0;
            qy_reg         <= '0;
            remx_reg       <= '0;
            remy_reg       <= '0;
            step_total_reg <= steps_w;
            step_index_reg <= '0;
            cen_x_reg      <= start_x;
            cen_y_reg      <= start_y;
            radius_reg     <= rad_w;
            rsq_reg        <= rsq_w;
            off_col_reg    <= -$signed({1'b0, rad_w});
            off_row_reg    <= -$signed({1'b0, rad_w});
            held_color_reg <= pen_color;
        end else if (cmd.eval && !is_last) begin
            if (!col_end) begin
                off_col_reg <= off_col_reg + OFF_BITS'(1);
            end else begin
                off_col_reg <= -rad_s;
                if (!row_end) begin
                    off_row_reg <= off_row_reg + OFF_BITS'(1);
                end else begin
                    off_row_reg    <= -rad_s;
                    step_index_reg <= step_index_reg + CW'(1);
                    qx_reg         <= qx_next;
                    qy_reg         <= qy_next;
                    remx_reg       <= remx_next;
                    remy_reg       <= remy_next;
                    cen_x_reg      <= cenx_next_w[CW-1:0];
                    cen_y_reg      <= ceny_next_w[CW-1:0];
                end
            end
        end
    end

    // candidate capture
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            cand_px_reg   <= px_w[CW-1:0];
            cand_py_reg   <= py_w[CW-1:0];
            cand_we_reg   <= in_disc && in_frame;
            cand_last_reg <= is_last;
        end
    end

    // row times pitch
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_reg <= PROD_BITS'(cand_py_reg) * PROD_BITS'(row_pitch_reg);
        end
    end

    assign addr_sum_w = {1'b0, prod_reg} + (PROD_BITS+1)'(cand_px_reg);

    // output register, skipped candidates carry zero payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            last_reg <= cand_last_reg;
            we_reg   <= cand_we_reg;
            if (cand_we_reg) begin
                addr_reg  <= OUT_ADDR_BITS'(addr_sum_w[ADDR_BITS-1:0]);
                col_reg   <= cand_px_reg[PIX_BITS-1:0];
                row_reg   <= cand_py_reg[PIX_BITS-1:0];
                color_reg <= held_color_reg;
            end else begin
                addr_reg  <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
                color_reg <= '0;
            end
        end
    end

    assign address      = addr_reg;
    assign pixel_col    = col_reg;
    assign pixel_row    = row_reg;
    assign write_color  = color_reg;
    assign write_enable = we_reg;
    assign last         = last_reg;

endmodule

// ===== sv/tlrc_ctrl.sv =====
// sequencer for line start, candidate evaluation, address multiply and output handoff
module tlrc_ctrl import tlrc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         op,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output tlrc_cmd_t    cmd,
    input  tlrc_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       busy_reg, busy_next;
    logic       m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (op == OP_START) begin
                        cmd.load_line = 1'b1;
                        busy_next     = 1'b1;
                    end else if (busy_reg) begin
                        cmd.eval   = 1'b1;
                        state_next = ST_MUL;
                        if (status.cand_last) begin
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;

    // a new result only comes out of the load state
    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_LOAD))
        else $error("result valid rose outside load state");

    // the multiply always hands over to the load state
    a_mul_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_LOAD)
        else $error("multiply state did not move to load");

    // a stalled output keeps the next result waiting
    a_load_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && m_valid_reg && !m_tready) |=>
        (state_reg == ST_LOAD && m_valid_reg))
        else $error("result overwritten while output stalled");

    // the line ends only on the last candidate
    a_busy_falls_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) |-> $past(cmd.eval && status.cand_last))
        else $error("line ended before its last candidate");

endmodule

// ===== sv/thick_line_round_cap_raster_core.sv =====
// top level of the thick line rasterizer with a round brush
// an advance transaction is evaluated on accept, multiplied, then loaded, which raises result valid
// s_tready is low in the multiply and load states, so a new advance waits for the last result
// a start transaction gives no result; an advance with no line loaded gives none
// line steps move the centre by one add and compare, so every candidate costs the same
// aresetn (synchronous, active low) clears control state and reloads frame register defaults
module thick_line_round_cap_raster_core import tlrc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]      cfg_data,
    // input stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // start_x, start_y, end_x, end_y, stroke_width, pen_color, zero pad
    input  logic [S_DATA_BITS-1:0]   s_tdata,
    // op
    input  logic                     s_tuser,
    // result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // address, pixel_col, pixel_row, write_color
    output logic [M_DATA_BITS-1:0]   m_tdata,
    // write_enable
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int CW = COORD_BITS;

    tlrc_cmd_t    cmd;
    tlrc_status_t status;

    logic signed [CW-1:0]     start_x, start_y, end_x, end_y;
    logic [WIDTH_BITS-1:0]    stroke_width;
    logic [COLOR_BITS-1:0]    pen_color;
    logic [OUT_ADDR_BITS-1:0] address;
    logic [PIX_BITS-1:0]      pixel_col, pixel_row;
    logic [COLOR_BITS-1:0]    write_color;

    // unpack input transaction
    assign start_x      = s_tdata[CW-1:0];
    assign start_y      = s_tdata[2*CW-1:CW];
    assign end_x        = s_tdata[3*CW-1:2*CW];
    assign end_y        = s_tdata[4*CW-1:3*CW];
    assign stroke_width = s_tdata[4*CW+WIDTH_BITS-1:4*CW];
    assign pen_color    = s_tdata[4*CW+WIDTH_BITS+COLOR_BITS-1:4*CW+WIDTH_BITS];

    tlrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tlrc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start_x      (start_x),
        .start_y      (start_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .stroke_width (stroke_width),
        .pen_color    (pen_color),
        .address      (address),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .write_color  (write_color),
        .write_enable (m_tuser),
        .last         (m_tlast)
    );

    // pack result transaction
    assign m_tdata = {write_color, pixel_row, pixel_col, address};

endmodule
